// ----- sv/tle_pkg.sv -----
`timescale 1ns / 1ps
package tle_pkg;

  localparam int unsigned LINE_MAX_DEF = 64;
  localparam int unsigned CFG_W        = 7;

  localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;
  localparam logic [CFG_W-1:0] CAP_MIN   = 7'd2;

  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] BYTE_CSI   = 8'h5B;
  localparam logic [7:0] BYTE_UP    = 8'h41;
  localparam logic [7:0] BYTE_DOWN  = 8'h42;
  localparam logic [7:0] BYTE_RIGHT = 8'h43;
  localparam logic [7:0] BYTE_LEFT  = 8'h44;
  localparam logic [7:0] BYTE_HOME  = 8'h31;
  localparam logic [7:0] BYTE_DEL   = 8'h33;
  localparam logic [7:0] BYTE_END   = 8'h34;
  localparam logic [7:0] BYTE_PGDN  = 8'h36;
  localparam logic [7:0] BYTE_TILDE = 8'h7E;
  localparam logic [7:0] BYTE_ENTER = 8'h0D;
  localparam logic [7:0] BYTE_BKSP  = 8'h7F;
  localparam logic [7:0] BYTE_SPACE = 8'h20;

  localparam logic [2:0] ESC_LAST_CNT = 3'd4;

  typedef enum logic [2:0] {
    KEY_NONE,
    KEY_BACK,
    KEY_FWD,
    KEY_START,
    KEY_ERASE,
    KEY_END,
    KEY_BYTE
  } key_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_SHIFT,
    CELL_DRAIN,
    CELL_CLEAR
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    cell_op_e   op;
    logic [7:0] wdata;
  } cell_cmd_t;

endpackage

// ----- sv/tle_cell.sv -----
`timescale 1ns / 1ps
module tle_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tle_pkg::cell_cmd_t cmd_i,
  input  logic [CW-1:0]      ptr_i,
  input  logic [CW-1:0]      lim_i,
  input  logic [7:0]         right_i,
  output logic [7:0]         data_o,
  output logic               hit_o
);
  import tle_pkg::*;

  localparam logic [CW-1:0] IDX_W = CW'(IDX);

  logic [7:0] data_q, data_d;
  logic       at_ptr;

  assign at_ptr = (IDX_W == ptr_i);
  assign data_o = data_q;
  assign hit_o  = at_ptr && (data_q != 8'h00);

  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      CELL_HOLD:  data_d = data_q;
      CELL_WRITE: begin
        if (at_ptr) begin
          data_d = cmd_i.wdata;
        end
      end
      CELL_SHIFT: begin
        if (IDX_W == lim_i) begin
          data_d = 8'h00;
        end else if ((IDX_W >= ptr_i) && (IDX_W < lim_i)) begin
          data_d = right_i;
        end
      end
      CELL_DRAIN: data_d = right_i;
      CELL_CLEAR: data_d = 8'h00;
      default:    data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= 8'h00;
    end else begin
      data_q <= data_d;
    end
  end

endmodule

// ----- sv/tle_esc_dec.sv -----
`timescale 1ns / 1ps
module tle_esc_dec (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [7:0]    byte_i,
  output tle_pkg::key_e key_o
);
  import tle_pkg::*;

  logic [2:0] count_q, count_d;
  logic [7:0] b0_q, b0_d;
  logic [7:0] b1_q, b1_d;

  always_comb begin
    count_d = count_q;
    b0_d    = b0_q;
    b1_d    = b1_q;
    key_o   = KEY_NONE;
    if (count_q == 3'd0) begin
      if (byte_i == BYTE_ESC) begin
        count_d = 3'd1;
      end else begin
        key_o = KEY_BYTE;
      end
    end else begin
      count_d = count_q + 3'd1;
      if (count_q == 3'd1) begin
        b0_d = byte_i;
      end
      if (count_q == 3'd2) begin
        b1_d = byte_i;
      end
      if ((count_q == 3'd2) && (b0_q == BYTE_CSI)) begin
        if ((byte_i == BYTE_UP) || (byte_i == BYTE_DOWN)) begin
          count_d = 3'd0;
        end else if (byte_i == BYTE_RIGHT) begin
          count_d = 3'd0;
          key_o   = KEY_FWD;
        end else if (byte_i == BYTE_LEFT) begin
          count_d = 3'd0;
          key_o   = KEY_BACK;
        end
      end else if ((count_q == 3'd3) && (b0_q == BYTE_CSI) && (byte_i == BYTE_TILDE)) begin
        if ((b1_q >= BYTE_HOME) && (b1_q <= BYTE_PGDN)) begin
          count_d = 3'd0;
          if (b1_q == BYTE_HOME) begin
            key_o = KEY_START;
          end else if (b1_q == BYTE_DEL) begin
            key_o = KEY_ERASE;
          end else if (b1_q == BYTE_END) begin
            key_o = KEY_END;
          end
        end
      end else if (count_q >= ESC_LAST_CNT) begin
        count_d = 3'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 3'd0;
      b0_q    <= 8'h00;
      b1_q    <= 8'h00;
    end else if (en_i) begin
      count_q <= count_d;
      b0_q    <= b0_d;
      b1_q    <= b1_d;
    end
  end

endmodule

// ----- sv/terminal_line_editor_unit.sv -----
`timescale 1ns / 1ps
// A byte is taken while the unit is idle; editing, cursor keys and escape bytes take effect at once.
// End walks the cursor one cell a cycle; no byte is taken until the walk is over.
// Enter emits one result a cycle, unless the output stalls, from the head of the cell row up to
// the cursor; the next byte is taken after the last result has entered the output register.
// Reset clears all cells, the cursor and the escape state at once and sets capacity to 64.
module terminal_line_editor_unit #(
  parameter int unsigned LINE_MAX = tle_pkg::LINE_MAX_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                rx_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                line_char_o,
  output logic                      char_valid_o,
  output logic                      last_char_o,
  input  logic                      cfg_we_i,
  input  logic [tle_pkg::CFG_W-1:0] cfg_wdata_i
);
  import tle_pkg::*;

  localparam int unsigned      CW     = $clog2(LINE_MAX);
  localparam logic [CFG_W-1:0] LINE_W = CFG_W'(LINE_MAX);

  state_e state_q, state_d;

  logic [CFG_W-1:0] cap_q;
  logic [CFG_W-1:0] cap_eff;
  logic [CFG_W-1:0] end_full;
  logic [CW-1:0]    end_c;
  logic [CW-1:0]    cursor_q, cursor_d;
  logic [CW-1:0]    cur_clamp;
  logic [CW-1:0]    rem_q, rem_d;
  logic [CW-1:0]    ptr;

  logic       accept;
  logic       out_free;
  logic       hit;
  logic       printable;
  key_e       key;
  cell_cmd_t  cmd;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q, out_char_d;
  logic       out_cv_q, out_cv_d;
  logic       out_last_q, out_last_d;

  logic [7:0]          cell_data [LINE_MAX];
  logic [LINE_MAX-1:0] hit_vec;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign accept       = in_valid_i && !in_stall_o;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign out_valid_o  = out_valid_q;
  assign line_char_o  = out_char_q;
  assign char_valid_o = out_cv_q;
  assign last_char_o  = out_last_q;

  assign cap_eff   = (cap_q < CAP_MIN) ? CAP_MIN : ((cap_q > LINE_W) ? LINE_W : cap_q);
  assign end_full  = cap_eff - CFG_W'(1);
  assign end_c     = end_full[CW-1:0];
  assign cur_clamp = (cursor_q > end_c) ? end_c : cursor_q;
  assign printable = (rx_byte_i >= BYTE_SPACE) && (rx_byte_i <= BYTE_TILDE);
  assign hit       = |hit_vec;

  tle_esc_dec u_esc_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (accept),
    .byte_i (rx_byte_i),
    .key_o  (key)
  );

  for (genvar g = 0; g < LINE_MAX; g++) begin : g_cell
    logic [7:0] right;
    if (g == LINE_MAX - 1) begin : g_tail
      assign right = 8'h00;
    end else begin : g_body
      assign right = cell_data[g+1];
    end
    tle_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .ptr_i   (ptr),
      .lim_i   (end_c),
      .right_i (right),
      .data_o  (cell_data[g]),
      .hit_o   (hit_vec[g])
    );
  end

  always_comb begin
    if (state_q == ST_SCAN) begin
      ptr = cursor_q;
    end else if ((key == KEY_BYTE) && (rx_byte_i == BYTE_BKSP) && (cur_clamp != '0)) begin
      ptr = cur_clamp - CW'(1);
    end else begin
      ptr = cur_clamp;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (key == KEY_END) begin
            state_d = ST_SCAN;
          end else if ((key == KEY_BYTE) && (rx_byte_i == BYTE_ENTER)) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_SCAN: begin
        if (!((cursor_q < end_c) && hit)) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free && (rem_q <= CW'(1))) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op      = CELL_HOLD;
    cmd.wdata   = rx_byte_i;
    cursor_d    = cursor_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_char_d  = out_char_q;
    out_cv_d    = out_cv_q;
    out_last_d  = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cursor_d = cur_clamp;
          case (key)
            KEY_BACK: begin
              if (cur_clamp != '0) begin
                cursor_d = cur_clamp - CW'(1);
              end
            end
            KEY_FWD: begin
              if (hit && (cur_clamp < end_c)) begin
                cursor_d = cur_clamp + CW'(1);
              end
            end
            KEY_START: cursor_d = '0;
            KEY_ERASE: cmd.op = CELL_SHIFT;
            KEY_BYTE: begin
              if (rx_byte_i == BYTE_ENTER) begin
                rem_d = cur_clamp;
              end else if (rx_byte_i == BYTE_BKSP) begin
                if (cur_clamp != '0) begin
                  cmd.op   = CELL_SHIFT;
                  cursor_d = cur_clamp - CW'(1);
                end
              end else if (printable) begin
                cmd.op = CELL_WRITE;
                if (cur_clamp < end_c) begin
                  cursor_d = cur_clamp + CW'(1);
                end
              end
            end
            default: cursor_d = cur_clamp;
          endcase
        end
      end
      ST_SCAN: begin
        if ((cursor_q < end_c) && hit) begin
          cursor_d = cursor_q + CW'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (rem_q == '0) begin
            out_char_d = 8'h00;
            out_cv_d   = 1'b0;
            out_last_d = 1'b1;
            cmd.op     = CELL_CLEAR;
            cursor_d   = '0;
          end else begin
            out_char_d = cell_data[0];
            out_cv_d   = 1'b1;
            out_last_d = (rem_q == CW'(1));
            rem_d      = rem_q - CW'(1);
            if (rem_q == CW'(1)) begin
              cmd.op   = CELL_CLEAR;
              cursor_d = '0;
            end else begin
              cmd.op = CELL_DRAIN;
            end
          end
        end
      end
      default: cmd.op = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CAP_RESET;
      cursor_q    <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_cv_q   <= out_cv_d;
    out_last_q <= out_last_d;
  end

endmodule

// ----- tb/tb_terminal_line_editor_unit.sv -----
`timescale 1ns / 1ps
module tb_terminal_line_editor_unit;
  import tle_pkg::*;

  localparam int unsigned LINE_MAX      = LINE_MAX_DEF;
  localparam int unsigned ESC_ARROW_LEN = 3;
  localparam int unsigned ESC_TILDE_LEN = 4;
  localparam int unsigned ESC_BAD_LEN   = 5;
  localparam int unsigned SETTLE_CYCLES = 2 * LINE_MAX + 8;
  localparam logic [7:0]  BYTE_INS      = 8'h32;
  localparam logic [7:0]  BYTE_PGUP     = 8'h35;
  localparam logic [7:0]  BYTE_NUL      = 8'h00;
  localparam logic [7:0]  BYTE_TOP      = 8'hFF;
  localparam logic [7:0]  BYTE_CTRL_A   = 8'h01;
  localparam logic [7:0]  BYTE_BAD_DIG  = 8'h39;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
  } line_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [7:0]       rx_byte_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [7:0]       line_char_o;
  logic             char_valid_o;
  logic             last_char_o;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  bit          idling_on;
  int unsigned bytes_sent;
  int unsigned results_checked;
  int unsigned lines_expected;
  int unsigned settings_written;
  int unsigned errors_count;

  line_result_t     pending_chars_q[$];
  logic [7:0]       line_cells[LINE_MAX];
  int unsigned      edit_cursor;
  int unsigned      esc_len;
  logic [7:0]       esc_seq[3];
  logic [CFG_W-1:0] capacity_reg;

  terminal_line_editor_unit #(
    .LINE_MAX(LINE_MAX)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .line_char_o (line_char_o),
    .char_valid_o(char_valid_o),
    .last_char_o (last_char_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: mismatch on %s, got 0x%0h, expected 0x%0h", $time, what, got, want);
    errors_count++;
  endtask

  function automatic void close_gap(input int unsigned from, input int unsigned cap);
    for (int unsigned i = from; i + 1 < cap; i++) begin
      line_cells[i] = line_cells[i + 1];
    end
    line_cells[cap - 1] = '0;
  endfunction

  function automatic void edit_line(input logic [7:0] b);
    int unsigned  cap;
    int unsigned  last_cell;
    int unsigned  cur;
    key_e         key;
    line_result_t r;
    cap = (capacity_reg < CAP_MIN) ? CAP_MIN :
          ((capacity_reg > LINE_MAX) ? LINE_MAX : capacity_reg);
    key = KEY_NONE;
    if (esc_len == 0) begin
      if (b == BYTE_ESC) begin
        esc_len = 1;
      end else begin
        key = KEY_BYTE;
      end
    end else begin
      if (esc_len <= 3) begin
        esc_seq[esc_len - 1] = b;
      end
      esc_len++;
      if (esc_len == ESC_ARROW_LEN && esc_seq[0] == BYTE_CSI) begin
        if (b == BYTE_UP || b == BYTE_DOWN) begin
          esc_len = 0;
        end else if (b == BYTE_RIGHT) begin
          esc_len = 0;
          key = KEY_FWD;
        end else if (b == BYTE_LEFT) begin
          esc_len = 0;
          key = KEY_BACK;
        end
      end else if (esc_len == ESC_TILDE_LEN && esc_seq[0] == BYTE_CSI && b == BYTE_TILDE) begin
        if (esc_seq[1] >= BYTE_HOME && esc_seq[1] <= BYTE_PGDN) begin
          esc_len = 0;
          if (esc_seq[1] == BYTE_HOME) key = KEY_START;
          else if (esc_seq[1] == BYTE_DEL) key = KEY_ERASE;
          else if (esc_seq[1] == BYTE_END) key = KEY_END;
        end
      end else if (esc_len >= ESC_BAD_LEN) begin
        esc_len = 0;
      end
    end

    last_cell = cap - 1;
    if (edit_cursor > last_cell) edit_cursor = last_cell;
    cur = edit_cursor;
    case (key)
      KEY_BACK: begin
        if (cur > 0) cur--;
      end
      KEY_FWD: begin
        if (line_cells[cur] != 0 && cur < last_cell) cur++;
      end
      KEY_START: begin
        cur = 0;
      end
      KEY_END: begin
        while (cur < last_cell && line_cells[cur] != 0) cur++;
      end
      KEY_ERASE: begin
        close_gap(cur, cap);
      end
      KEY_BYTE: begin
        if (b == BYTE_ENTER) begin
          if (cur == 0) begin
            r = '{8'h00, 1'b0, 1'b1};
            pending_chars_q.push_back(r);
          end else begin
            for (int unsigned k = 0; k < cur; k++) begin
              r = '{line_cells[k], 1'b1, k + 1 == cur};
              pending_chars_q.push_back(r);
            end
          end
          lines_expected++;
          foreach (line_cells[i]) line_cells[i] = '0;
          cur = 0;
        end else if (b == BYTE_BKSP) begin
          if (cur > 0) begin
            close_gap(cur - 1, cap);
            cur--;
          end
        end else if (b >= BYTE_SPACE && b <= BYTE_TILDE) begin
          line_cells[cur] = b;
          if (cur < last_cell) cur++;
        end
      end
      default: begin
      end
    endcase
    edit_cursor = cur;
  endfunction

  // Entered and left at a falling edge with in_valid_i low.
  task automatic send_byte(input logic [7:0] b);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    rx_byte_i  = b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    edit_line(b);
    bytes_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_arrow(input logic [7:0] code);
    send_byte(BYTE_ESC);
    send_byte(BYTE_CSI);
    send_byte(code);
  endtask

  task automatic send_tilde_key(input logic [7:0] digit);
    send_byte(BYTE_ESC);
    send_byte(BYTE_CSI);
    send_byte(digit);
    send_byte(BYTE_TILDE);
  endtask

  task automatic wait_drained();
    while (pending_chars_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i     = 1'b0;
    capacity_reg = value;
    settings_written++;
  endtask

  always @(posedge clk_i) begin : check_result
    line_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars_q.size() == 0) begin
        report_mismatch("result with nothing pending", line_char_o, 0);
      end else begin
        want = pending_chars_q.pop_front();
        results_checked++;
        if (line_char_o !== want.ch) report_mismatch("line_char", line_char_o, want.ch);
        if (char_valid_o !== want.has_char) begin
          report_mismatch("char_valid", char_valid_o, want.has_char);
        end
        if (last_char_o !== want.last) report_mismatch("last_char", last_char_o, want.last);
      end
    end
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idling_on && $urandom_range(0, 7) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  task automatic test_empty_line();
    send_byte(BYTE_ENTER);
  endtask

  task automatic test_printable_range();
    send_byte(BYTE_SPACE);
    send_byte(BYTE_NUL);
    send_byte(BYTE_TILDE);
    send_byte(BYTE_TOP);
    send_byte(BYTE_ENTER);
  endtask

  task automatic test_edit_keys();
    send_byte("a");
    send_byte("b");
    send_byte("c");
    send_arrow(BYTE_LEFT);
    send_byte(BYTE_BKSP);
    send_tilde_key(BYTE_HOME);
    send_tilde_key(BYTE_DEL);
    send_tilde_key(BYTE_END);
    send_arrow(BYTE_RIGHT);
    send_byte(BYTE_ENTER);
  endtask

  task automatic test_ignored_keys();
    send_byte("m");
    send_arrow(BYTE_UP);
    send_arrow(BYTE_DOWN);
    send_tilde_key(BYTE_INS);
    send_tilde_key(BYTE_PGUP);
    send_tilde_key(BYTE_PGDN);
    send_byte(BYTE_CTRL_A);
    send_byte(BYTE_ENTER);
  endtask

  task automatic test_bad_escapes();
    send_byte("k");
    send_tilde_key(BYTE_BAD_DIG);
    send_byte("x");
    repeat (ESC_BAD_LEN) send_byte(BYTE_ESC);
    send_byte(BYTE_ENTER);
  endtask

  task automatic test_capacity_limits();
    write_capacity('0);
    send_byte("a");
    send_byte("b");
    send_byte("c");
    send_byte(BYTE_ENTER);
    write_capacity('1);
    send_byte("w");
    send_byte("x");
    send_byte("y");
    send_byte("z");
    write_capacity(7'd3);
    send_byte("Q");
    send_byte(BYTE_BKSP);
    send_byte(BYTE_ENTER);
  endtask

  task automatic test_random_edits(input logic [CFG_W-1:0] cap, input int unsigned n_items,
                                   input int unsigned print_pct,
                                   input int unsigned enter_one_in);
    int unsigned start;
    int unsigned pick;
    write_capacity(cap);
    start = bytes_sent;
    while (bytes_sent - start < n_items) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(1, enter_one_in) == 1) begin
        send_byte(BYTE_ENTER);
      end else if (pick < print_pct) begin
        send_byte(8'($urandom_range(BYTE_SPACE, BYTE_TILDE)));
      end else begin
        case ($urandom_range(0, 16))
          0: send_arrow(BYTE_UP);
          1: send_arrow(BYTE_DOWN);
          2, 3: send_arrow(BYTE_RIGHT);
          4, 5: send_arrow(BYTE_LEFT);
          6: send_tilde_key(BYTE_HOME);
          7: send_tilde_key(BYTE_INS);
          8: send_tilde_key(BYTE_DEL);
          9: send_tilde_key(BYTE_END);
          10: send_tilde_key(BYTE_PGUP);
          11: send_tilde_key(BYTE_PGDN);
          12, 13: send_byte(BYTE_BKSP);
          14: begin
            send_byte(BYTE_ESC);
            if ($urandom_range(0, 1) == 1) send_byte(BYTE_CSI);
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
          end
          default: begin
            send_byte(8'($urandom_range(0, 255)));
          end
        endcase
      end
    end
  endtask

  initial begin
    in_valid_i   = 1'b0;
    rx_byte_i    = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    rst_ni       = 1'b0;
    idling_on    = 1'b1;
    foreach (line_cells[i]) line_cells[i] = '0;
    foreach (esc_seq[i]) esc_seq[i] = '0;
    edit_cursor  = 0;
    esc_len      = 0;
    capacity_reg = CAP_RESET;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_line();
    test_printable_range();
    test_edit_keys();
    test_ignored_keys();
    test_bad_escapes();
    test_capacity_limits();

    test_random_edits(7'd64, 64, 60, 12);
    test_random_edits(CAP_MIN, 32, 60, 4);
    test_random_edits(7'd0, 24, 60, 4);
    test_random_edits(7'd7, 48, 55, 8);
    test_random_edits(7'd127, 80, 90, 90);
    test_random_edits(7'($urandom_range(0, 127)), 48, 60, 10);
    idling_on = 1'b0;
    test_random_edits(7'($urandom_range(0, 127)), 48, 60, 10);

    wait_drained();
    $display("Sent %0d bytes under %0d capacity settings, with both sides idling in bursts.",
             bytes_sent, settings_written);
    $display("Checked %0d result transactions across %0d emitted lines.",
             results_checked, lines_expected);
    if (errors_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
